FILE: design/lfa_pkg.sv
`default_nettype none

package lfa_pkg;

  // Field widths.
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned CODE_W    = 8;
  localparam int unsigned CMD_W     = 2;
  localparam int unsigned PERIOD_W  = 15;
  localparam int unsigned ELAPSED_W = 24;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;

  // Command codes of an input transaction.
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUTE  = 2'd2;

  // Effect codes.
  localparam logic [CODE_W-1:0] EFF_NONE      = 8'h00;
  localparam logic [CODE_W-1:0] EFF_BLANK     = 8'h01;
  localparam logic [CODE_W-1:0] EFF_CONST     = 8'h02;
  localparam logic [CODE_W-1:0] EFF_FADE_UP   = 8'h10;
  localparam logic [CODE_W-1:0] EFF_FADE_DOWN = 8'h11;
  localparam logic [CODE_W-1:0] EFF_FLASH     = 8'h20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_A      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_B      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_B       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_COUNT = 2'd3;

  // One 10 ms unit counts as this many 100 us ticks.
  localparam logic [6:0] TICKS_PER_10MS = 7'd100;

  // The elapsed tick counter stops here.
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = {ELAPSED_W{1'b1}};

  typedef struct packed {
    logic [LEVEL_W-1:0] level_a;
    logic [LEVEL_W-1:0] level_b;
    logic [LEVEL_W-1:0] time_b;
    logic [LEVEL_W-1:0] repeat_count;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CODE_W-1:0] effect_code;
    logic              mute_on;
  } item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] drive_level;
    logic               drive_written;
    logic [CODE_W-1:0]  active_effect;
  } result_t;

  typedef struct packed {
    logic [LEVEL_W-1:0]   current_level;
    logic [CODE_W-1:0]    effect_now;
    logic [LEVEL_W-1:0]   repeats_left;
    logic [PERIOD_W-1:0]  step_period;
    logic [ELAPSED_W-1:0] elapsed_ticks;
    logic                 flash_phase_on;
    logic                 muted;
  } anim_state_t;

  // Converts a time in 10 ms units into a period in ticks (at most 25500).
  function automatic logic [PERIOD_W-1:0] ticks_of_10ms(input logic [LEVEL_W-1:0] units);
    return PERIOD_W'(units) * PERIOD_W'(TICKS_PER_10MS);
  endfunction

endpackage

`default_nettype wire

FILE: design/lfa_in_if.sv
`default_nettype none

interface lfa_in_if;
  logic                         valid;
  logic                         ready;
  logic [lfa_pkg::CMD_W-1:0]    cmd;
  logic [lfa_pkg::CODE_W-1:0]   effect_code;
  logic                         mute_on;

  modport source (output valid, output cmd, output effect_code, output mute_on,
                  input ready);
  modport sink (input valid, input cmd, input effect_code, input mute_on,
                output ready);
endinterface

`default_nettype wire

FILE: design/lfa_out_if.sv
`default_nettype none

interface lfa_out_if;
  logic                         valid;
  logic                         ready;
  logic [lfa_pkg::LEVEL_W-1:0]  drive_level;
  logic                         drive_written;
  logic [lfa_pkg::CODE_W-1:0]   active_effect;

  modport source (output valid, output drive_level, output drive_written,
                  output active_effect, input ready);
  modport sink (input valid, input drive_level, input drive_written,
                input active_effect, output ready);
endinterface

`default_nettype wire

FILE: design/lfa_cfg_regs.sv
`default_nettype none

module lfa_cfg_regs (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [lfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lfa_pkg::CFG_W-1:0]      cfg_wdata_i,
  output lfa_pkg::cfg_t                       cfg_o
);
  import lfa_pkg::*;

  cfg_t cfg_q;

  // Register file: one 8-bit register per index, written without wait.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LEVEL_A:      cfg_q.level_a      <= cfg_wdata_i;
        REG_LEVEL_B:      cfg_q.level_b      <= cfg_wdata_i;
        REG_TIME_B:       cfg_q.time_b       <= cfg_wdata_i;
        REG_REPEAT_COUNT: cfg_q.repeat_count <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: design/lfa_next.sv
`default_nettype none

module lfa_next (
  input  wire lfa_pkg::anim_state_t state_i,
  input  wire lfa_pkg::item_t       item_i,
  input  wire lfa_pkg::cfg_t        cfg_i,
  output lfa_pkg::anim_state_t      state_o,
  output lfa_pkg::result_t          result_o
);
  import lfa_pkg::*;

  anim_state_t            st;
  logic                   wr;
  logic [LEVEL_W-1:0]     wr_level;
  logic [ELAPSED_W-1:0]   elapsed_inc;
  logic [LEVEL_W-1:0]     rl_dec;
  logic                   stepping;
  logic                   fire;
  logic                   counted;

  // Saturating tick count and the step decision.
  assign elapsed_inc = (state_i.elapsed_ticks < ELAPSED_MAX) ?
                       state_i.elapsed_ticks + ELAPSED_W'(1) : state_i.elapsed_ticks;
  assign rl_dec      = state_i.repeats_left - LEVEL_W'(1);
  assign counted     = (cfg_i.repeat_count != '0);
  assign stepping    = state_i.effect_now inside {EFF_FADE_UP, EFF_FADE_DOWN, EFF_FLASH};
  assign fire        = !state_i.muted && stepping &&
                       (elapsed_inc > ELAPSED_W'(state_i.step_period));

  // Next state and the level written by this transaction.
  always_comb begin
    st       = state_i;
    wr       = 1'b0;
    wr_level = '0;
    case (item_i.cmd)
      CMD_TICK: begin
        st.elapsed_ticks = elapsed_inc;
        if (fire) begin
          st.elapsed_ticks = elapsed_inc - ELAPSED_W'(state_i.step_period);
          case (state_i.effect_now)
            EFF_FADE_UP: begin
              if (state_i.current_level >= cfg_i.level_b) begin
                st.current_level = cfg_i.level_a;
                if (counted) begin
                  st.repeats_left = rl_dec;
                  if (rl_dec == '0) begin
                    st.effect_now = EFF_NONE;
                  end
                end
              end else begin
                st.current_level = state_i.current_level + LEVEL_W'(1);
              end
              wr       = 1'b1;
              wr_level = st.current_level;
            end
            EFF_FADE_DOWN: begin
              if (state_i.current_level <= cfg_i.level_b) begin
                st.current_level = cfg_i.level_a;
                if (counted) begin
                  st.repeats_left = rl_dec;
                  // The last ramp ends on the stop level.
                  if (rl_dec == '0) begin
                    st.effect_now    = EFF_NONE;
                    st.current_level = cfg_i.level_b;
                  end
                end
              end else begin
                st.current_level = state_i.current_level - LEVEL_W'(1);
              end
              wr       = 1'b1;
              wr_level = st.current_level;
            end
            default: begin
              // Flash: toggle between the on level and zero.
              if (state_i.flash_phase_on) begin
                st.flash_phase_on = 1'b0;
                st.current_level  = '0;
                st.step_period    = ticks_of_10ms(cfg_i.time_b);
                wr                = 1'b1;
                wr_level          = '0;
                if (counted) begin
                  st.repeats_left = rl_dec;
                  if (rl_dec == '0) begin
                    st.effect_now = EFF_NONE;
                  end
                end
              end else begin
                st.flash_phase_on = 1'b1;
                st.current_level  = cfg_i.level_a;
                st.step_period    = ticks_of_10ms(cfg_i.level_b);
                wr                = 1'b1;
                wr_level          = cfg_i.level_a;
              end
            end
          endcase
        end
      end
      CMD_START: begin
        st.effect_now = item_i.effect_code;
        if (!state_i.muted) begin
          case (item_i.effect_code)
            EFF_BLANK: begin
              st.current_level = '0;
              wr               = 1'b1;
              wr_level         = '0;
            end
            EFF_CONST: begin
              st.current_level = cfg_i.level_a;
              wr               = 1'b1;
              wr_level         = cfg_i.level_a;
            end
            EFF_FADE_UP, EFF_FADE_DOWN: begin
              st.elapsed_ticks = '0;
              st.current_level = cfg_i.level_a;
              st.repeats_left  = cfg_i.repeat_count;
              st.step_period   = PERIOD_W'(cfg_i.time_b);
              wr               = 1'b1;
              wr_level         = cfg_i.level_a;
            end
            EFF_FLASH: begin
              st.elapsed_ticks  = '0;
              st.repeats_left   = cfg_i.repeat_count;
              st.step_period    = ticks_of_10ms(cfg_i.level_b);
              st.current_level  = cfg_i.level_a;
              st.flash_phase_on = 1'b1;
              wr                = 1'b1;
              wr_level          = cfg_i.level_a;
            end
            default: ;
          endcase
        end
      end
      CMD_MUTE: begin
        // Muting blanks the output but keeps the held level.
        st.muted = item_i.mute_on;
        wr       = 1'b1;
        wr_level = item_i.mute_on ? '0 : state_i.current_level;
      end
      default: ;
    endcase
  end

  assign state_o                = st;
  assign result_o.drive_level   = wr_level;
  assign result_o.drive_written = wr;
  assign result_o.active_effect = st.effect_now;

endmodule

`default_nettype wire

FILE: design/pwm_level_fade_flash_animator.sv
`default_nettype none

// PWM level animator: drives one 8-bit PWM level with blank, constant,
// fade and flash effects.
//
// Channels: in_i carries one transaction per command (tick of 100 us,
// effect start, or mute control); out_o returns exactly one result per
// input transaction, in order: the level written, a written flag and the
// effect code now held. The configuration port writes one of four 8-bit
// registers per cycle while cfg_we_i is high; it is meant to be used while
// no transaction is in flight.
//
// Each transaction is held in the input register, then its result in the
// result register. Throughput is one transaction per cycle while out_o.ready
// is high, set by one input register, next-state logic and result register.
// When the receiver stalls, the result register holds, the input register
// keeps its transaction, and in_i.ready drops once both are full.
// Reset clears all configuration registers, the effect state and both
// valid flags; no clearing pass is needed.
module pwm_level_fade_flash_animator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  lfa_in_if.sink                              in_i,
  lfa_out_if.source                           out_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [lfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [lfa_pkg::CFG_W-1:0]      cfg_wdata_i
);
  import lfa_pkg::*;

  cfg_t        cfg;
  logic        in_valid_q;
  item_t       in_item_q;
  anim_state_t state_q;
  anim_state_t state_d;
  result_t     result_d;
  logic        out_valid_q;
  result_t     out_res_q;
  logic        advance;

  lfa_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lfa_next u_next (
    .state_i  (state_q),
    .item_i   (in_item_q),
    .cfg_i    (cfg),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // The held transaction moves on when the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  // Valid flags and effect state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
        state_q     <= state_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_item_q.cmd         <= in_i.cmd;
      in_item_q.effect_code <= in_i.effect_code;
      in_item_q.mute_on     <= in_i.mute_on;
    end
    if (advance) begin
      out_res_q <= result_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.drive_level   = out_res_q.drive_level;
  assign out_o.drive_written = out_res_q.drive_written;
  assign out_o.active_effect = out_res_q.active_effect;

  // A transaction that moves on always shows up as a result.
  a_advance_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("result register not loaded after advance");

  // A blocked transaction stays in the input register unchanged.
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_item_q)))
    else $error("input register lost a blocked transaction");

  // A result that writes nothing reports level zero.
  a_level_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_res_q.drive_written) |-> (out_res_q.drive_level == '0))
    else $error("unwritten result carries a level");

  // The step period never exceeds the longest flash phase.
  a_period_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.step_period <= ticks_of_10ms({LEVEL_W{1'b1}}))
    else $error("step period out of range");

endmodule

`default_nettype wire
